@@ design/assert_macros.svh @@
// assertion macros for the checked module (cet_back)
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge out of reset
`define CET_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// same-cycle implication
`define CET_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

@@ design/cet_pkg.sv @@
// shared types and constants of the centroid edge test unit
// no dependencies
package cet_pkg;

	localparam int unsigned MAX_NEIGHBORS = 64;
	localparam int unsigned ID_W = 16;
	localparam int unsigned POS_W = 32;
	localparam int unsigned EDGE_W = POS_W + 1;
	localparam int unsigned DIFF_W = POS_W + 2;
	localparam int unsigned RED_STEPS = 4;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [POS_W-1:0] BOX_RESET = 32'h0010_0000;
	localparam logic REG_BOX = 1'b0;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BOND  = 2'd1,
		MODE_CAND  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// work item handed from front to back
	typedef struct packed {
		mode_t                     mode;
		logic [ID_W-1:0]           id;
		logic [ID_W-1:0]           center;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic signed [DIFF_W-1:0]  dz;
	} work_t;

endpackage

@@ design/cet_if.sv @@
// valid/ready channel interfaces for atom items and edge results
// depends on cet_pkg
interface cet_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [cet_pkg::ID_W-1:0]    atom_id;
	logic [cet_pkg::POS_W-1:0]   pos_x;
	logic [cet_pkg::POS_W-1:0]   pos_y;
	logic [cet_pkg::POS_W-1:0]   pos_z;
	modport source (output valid, mode, atom_id, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, mode, atom_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface cet_out_if;
	logic                        valid;
	logic                        ready;
	logic                        add_edge;
	logic [cet_pkg::ID_W-1:0]    center_id;
	logic [cet_pkg::ID_W-1:0]    partner_id;
	logic                        overflowed;
	modport source (output valid, add_edge, center_id, partner_id, overflowed, input ready);
	modport sink (input valid, add_edge, center_id, partner_id, overflowed, output ready);
endinterface

@@ design/centroid_edge_test_unit.sv @@
// Items pass front, queue and back in turn, one item at a time in the front. A start or idle item
// goes straight to push; a neighbor or candidate first goes through the reduce state (modulo
// lanes, 4 remainder bits per cycle). The back handles a start or neighbor in one exec step and a
// candidate in 18 products on one shared 32x32 multiplier before the compare.
// Reset (arst_n low, asynchronous) empties queue and output, box 16.0, center and sums zero.
module centroid_edge_test_unit #(
	parameter int unsigned MAX_NEIGHBORS = cet_pkg::MAX_NEIGHBORS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	cet_in_if.sink                      items,
	cet_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cet_pkg::PADDR_W-1:0] paddr,
	input  logic [cet_pkg::PDATA_W-1:0] pwdata,
	output logic [cet_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	logic [cet_pkg::POS_W-1:0] box_q;
	logic                      q_push_valid;
	logic                      q_push_ready;
	cet_pkg::work_t            q_push_data;
	logic                      q_pop_valid;
	logic                      q_pop_ready;
	cet_pkg::work_t            q_pop_data;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cet_pkg::REG_BOX) ? box_q : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= cet_pkg::BOX_RESET;
		end else if (psel && penable && pwrite && paddr[2] == cet_pkg::REG_BOX) begin
			box_q <= pwdata;
		end
	end

	cet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.box        (box_q),
		.items      (items),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	cet_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	cet_back #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.results   (results)
	);

endmodule

@@ design/cet_front.sv @@
// front end: accepts items, tracks the center, reduces coordinates modulo the box
// depends on cet_pkg and cet_in_if
module cet_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cet_pkg::POS_W-1:0] box,
	cet_in_if.sink                    items,
	output logic                      push_valid,
	input  logic                      push_ready,
	output cet_pkg::work_t            push_data
);

	localparam int unsigned RED_CYC = cet_pkg::POS_W / cet_pkg::RED_STEPS;
	localparam int unsigned STEP_W = $clog2(RED_CYC);
	localparam int unsigned LANES = 6;

	typedef enum logic [2:0] {
		FS_IDLE   = 3'b001,
		FS_REDUCE = 3'b010,
		FS_PUSH   = 3'b100
	} fstate_t;

	fstate_t                          state_q;
	cet_pkg::mode_t                   mode_q;
	logic [cet_pkg::ID_W-1:0]         id_q;
	logic [cet_pkg::ID_W-1:0]         center_id_q;
	logic [cet_pkg::POS_W-1:0]        cpos_q [3];
	logic [cet_pkg::POS_W-1:0]        dvd_q [LANES];
	logic [cet_pkg::EDGE_W-1:0]       rem_q [LANES];
	logic [cet_pkg::POS_W-1:0]        dvd_nxt [LANES];
	logic [cet_pkg::EDGE_W-1:0]       rem_nxt [LANES];
	logic [STEP_W-1:0]                step_q;
	logic [cet_pkg::EDGE_W-1:0]       edge_len;
	cet_pkg::mode_t                   in_mode;

	// minimum-image component from reduced center and neighbor coordinates
	function automatic logic signed [cet_pkg::DIFF_W-1:0] min_img(
		input logic [cet_pkg::EDGE_W-1:0] c,
		input logic [cet_pkg::EDGE_W-1:0] n,
		input logic [cet_pkg::EDGE_W-1:0] e
	);
		logic [cet_pkg::EDGE_W-1:0] r;
		logic [cet_pkg::DIFF_W-1:0] r2;
		r = (n >= c) ? (n - c) : (n + e - c);
		r2 = {r, 1'b0};
		if (r2 > {1'b0, e}) begin
			return $signed({1'b0, r}) - $signed({1'b0, e});
		end
		return $signed({1'b0, r});
	endfunction

	// a zero box means plain 32-bit wrap
	assign edge_len = {(box == '0), box};
	assign in_mode = cet_pkg::mode_t'(items.mode);
	assign items.ready = (state_q == FS_IDLE);
	assign push_valid = (state_q == FS_PUSH);

	// restoring remainder, several bits per cycle in every lane
	always_comb begin
		logic [cet_pkg::EDGE_W:0] r;
		logic [cet_pkg::POS_W-1:0] d;
		for (int l = 0; l < LANES; l++) begin
			r = {1'b0, rem_q[l]};
			d = dvd_q[l];
			for (int b = 0; b < cet_pkg::RED_STEPS; b++) begin
				r = {r[cet_pkg::EDGE_W-1:0], d[cet_pkg::POS_W-1]};
				d = {d[cet_pkg::POS_W-2:0], 1'b0};
				if (r >= {1'b0, edge_len}) begin
					r = r - {1'b0, edge_len};
				end
			end
			rem_nxt[l] = r[cet_pkg::EDGE_W-1:0];
			dvd_nxt[l] = d;
		end
	end

	// work item to the queue
	always_comb begin
		push_data.mode = mode_q;
		push_data.id = id_q;
		push_data.center = center_id_q;
		push_data.dx = min_img(rem_q[0], rem_q[3], edge_len);
		push_data.dy = min_img(rem_q[1], rem_q[4], edge_len);
		push_data.dz = min_img(rem_q[2], rem_q[5], edge_len);
	end

	// control and center state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			center_id_q <= '0;
			cpos_q[0] <= '0;
			cpos_q[1] <= '0;
			cpos_q[2] <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				FS_IDLE: begin
					if (items.valid) begin
						step_q <= '0;
						if (in_mode == cet_pkg::MODE_START) begin
							center_id_q <= items.atom_id;
							cpos_q[0] <= items.pos_x;
							cpos_q[1] <= items.pos_y;
							cpos_q[2] <= items.pos_z;
							state_q <= FS_PUSH;
						end else if (in_mode inside {cet_pkg::MODE_BOND,
						                             cet_pkg::MODE_CAND}) begin
							state_q <= FS_REDUCE;
						end else begin
							state_q <= FS_PUSH;
						end
					end
				end
				FS_REDUCE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(RED_CYC - 1)) begin
						state_q <= FS_PUSH;
					end
				end
				FS_PUSH: begin
					if (push_ready) begin
						state_q <= FS_IDLE;
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	// item payload and reduction lanes
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && items.valid) begin
			mode_q <= in_mode;
			id_q <= items.atom_id;
			dvd_q[0] <= cpos_q[0];
			dvd_q[1] <= cpos_q[1];
			dvd_q[2] <= cpos_q[2];
			dvd_q[3] <= items.pos_x;
			dvd_q[4] <= items.pos_y;
			dvd_q[5] <= items.pos_z;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (state_q == FS_REDUCE) begin
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= rem_nxt[l];
				dvd_q[l] <= dvd_nxt[l];
			end
		end
	end

endmodule

@@ design/cet_queue.sv @@
// short work queue between front and back
// depends on cet_pkg
module cet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cet_pkg::work_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cet_pkg::work_t  pop_data
);

	localparam int unsigned PTR_W = $clog2(cet_pkg::QDEPTH);
	localparam int unsigned CNT_W = $clog2(cet_pkg::QDEPTH + 1);

	cet_pkg::work_t      slot_q [cet_pkg::QDEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(cet_pkg::QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/cet_back.sv @@
// back end: neighbor sum, count and the division-free centroid test
// depends on cet_pkg, cet_out_if and assert_macros.svh
`include "assert_macros.svh"
module cet_back #(
	parameter int unsigned MAX_NEIGHBORS = cet_pkg::MAX_NEIGHBORS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  cet_pkg::work_t  pop_data,
	cet_out_if.source       results
);

	localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int unsigned NW = $clog2(MAX_NEIGHBORS + 2);
	localparam int unsigned SW = cet_pkg::DIFF_W + CNT_W;
	localparam int unsigned CW = SW + 1;
	localparam int unsigned PW = CW + NW;
	localparam int unsigned AW = 2 * PW + 2;

	typedef enum logic [6:0] {
		BS_IDLE  = 7'b0000001,
		BS_EXEC  = 7'b0000010,
		BS_SCALE = 7'b0000100,
		BS_MUL   = 7'b0001000,
		BS_ACC   = 7'b0010000,
		BS_CMP   = 7'b0100000,
		BS_DONE  = 7'b1000000
	} bstate_t;

	bstate_t                state_q;
	cet_pkg::work_t         job_q;
	logic signed [SW-1:0]   sum_q [3];
	logic [CNT_W-1:0]       cnt_q;
	logic                   drop_q;
	logic                   edge_q;
	logic [2:0]             vec_q;
	logic [1:0]             pp_q;
	logic [PW-1:0]          scaled_q;
	logic [63:0]            prod_q;
	logic [AW-1:0]          lhs_q;
	logic [AW-1:0]          rhs_q;
	logic                   out_valid_q;
	logic                   out_edge_q;
	logic [cet_pkg::ID_W-1:0] out_center_q;
	logic [cet_pkg::ID_W-1:0] out_partner_q;
	logic                   out_ovf_q;

	logic signed [CW-1:0]   sel_vec;
	logic [CW-1:0]          sel_mag;
	logic [NW-1:0]          factor;
	logic [31:0]            op_a;
	logic [31:0]            op_b;
	logic [31:0]            lo_part;
	logic [31:0]            hi_part;
	logic [AW-1:0]          addend;
	logic                   out_load;

	assign pop_ready = (state_q == BS_IDLE);
	assign out_load = (state_q == BS_DONE) && (!out_valid_q || results.ready);

	// pick the vector component and its count factor
	always_comb begin
		case (vec_q)
			3'd0: sel_vec = CW'(sum_q[0]) + CW'(job_q.dx);
			3'd1: sel_vec = CW'(sum_q[1]) + CW'(job_q.dy);
			3'd2: sel_vec = CW'(sum_q[2]) + CW'(job_q.dz);
			3'd3: sel_vec = CW'(sum_q[0]);
			3'd4: sel_vec = CW'(sum_q[1]);
			default: sel_vec = CW'(sum_q[2]);
		endcase
		sel_mag = sel_vec[CW-1] ? CW'(-sel_vec) : CW'(sel_vec);
		factor = (vec_q < 3'd3) ? NW'(cnt_q) : (NW'(cnt_q) + 1'b1);
	end

	// partial-product operands of the square
	assign lo_part = scaled_q[31:0];
	assign hi_part = 32'(scaled_q[PW-1:32]);
	always_comb begin
		case (pp_q)
			2'd0: begin
				op_a = lo_part;
				op_b = lo_part;
				addend = AW'(prod_q);
			end
			2'd1: begin
				op_a = lo_part;
				op_b = hi_part;
				addend = AW'(prod_q) << 33;
			end
			default: begin
				op_a = hi_part;
				op_b = hi_part;
				addend = AW'(prod_q) << 64;
			end
		endcase
	end

	// sequencer and neighbor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			cnt_q <= '0;
			drop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BS_IDLE: begin
					if (pop_valid) begin
						state_q <= BS_EXEC;
					end
				end
				BS_EXEC: begin
					case (job_q.mode)
						cet_pkg::MODE_START: begin
							sum_q[0] <= '0;
							sum_q[1] <= '0;
							sum_q[2] <= '0;
							cnt_q <= '0;
							drop_q <= 1'b0;
							state_q <= BS_DONE;
						end
						cet_pkg::MODE_BOND: begin
							if (cnt_q < CNT_W'(MAX_NEIGHBORS)) begin
								sum_q[0] <= sum_q[0] + SW'(job_q.dx);
								sum_q[1] <= sum_q[1] + SW'(job_q.dy);
								sum_q[2] <= sum_q[2] + SW'(job_q.dz);
								cnt_q <= cnt_q + 1'b1;
							end else begin
								drop_q <= 1'b1;
							end
							state_q <= BS_DONE;
						end
						cet_pkg::MODE_CAND: state_q <= BS_SCALE;
						default: state_q <= BS_DONE;
					endcase
				end
				BS_SCALE: state_q <= BS_MUL;
				BS_MUL: state_q <= BS_ACC;
				BS_ACC: begin
					if (pp_q != 2'd2) begin
						state_q <= BS_MUL;
					end else if (vec_q == 3'd5) begin
						state_q <= BS_CMP;
					end else begin
						state_q <= BS_SCALE;
					end
				end
				BS_CMP: state_q <= BS_DONE;
				BS_DONE: begin
					if (out_load) begin
						state_q <= BS_IDLE;
					end
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

	// datapath of the magnitude test
	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: begin
				job_q <= pop_data;
			end
			BS_EXEC: begin
				edge_q <= 1'b0;
				vec_q <= '0;
				lhs_q <= '0;
				rhs_q <= '0;
			end
			BS_SCALE: begin
				scaled_q <= PW'(sel_mag) * PW'(factor);
				pp_q <= '0;
			end
			BS_MUL: begin
				prod_q <= op_a * op_b;
			end
			BS_ACC: begin
				if (vec_q < 3'd3) begin
					lhs_q <= lhs_q + addend;
				end else begin
					rhs_q <= rhs_q + addend;
				end
				if (pp_q == 2'd2) begin
					vec_q <= vec_q + 1'b1;
				end
				pp_q <= pp_q + 1'b1;
			end
			BS_CMP: begin
				edge_q <= (lhs_q < rhs_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_edge_q <= edge_q;
			out_center_q <= job_q.center;
			out_partner_q <= job_q.id;
			out_ovf_q <= drop_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.add_edge = out_edge_q;
	assign results.center_id = out_center_q;
	assign results.partner_id = out_partner_q;
	assign results.overflowed = out_ovf_q;

	`CET_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_NEIGHBORS))
	`CET_ASSERT(a_drop_full, clk, arst_n, !drop_q || cnt_q == CNT_W'(MAX_NEIGHBORS))
	`CET_IMPLY(a_edge_cand, clk, arst_n, state_q == BS_DONE && job_q.mode != cet_pkg::MODE_CAND, !edge_q)

endmodule

@@ bench/tb_centroid_edge_test_unit.sv @@
// self-checking bench for centroid_edge_test_unit: random and directed atom items
// depends on cet_pkg, cet_if.sv and the unit itself
module tb_centroid_edge_test_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// one predicted edge result
	typedef struct {
		logic                     add_edge;
		logic [cet_pkg::ID_W-1:0] center_id;
		logic [cet_pkg::ID_W-1:0] partner_id;
		logic                     overflowed;
	} edge_result_t;

	// bond predictor plus queue of pending edge results
	class edge_scoreboard;
		logic [cet_pkg::POS_W-1:0]  box;
		logic [cet_pkg::POS_W-1:0]  cx, cy, cz;
		logic [cet_pkg::ID_W-1:0]   center;
		longint                     sx, sy, sz;
		int unsigned                count;
		logic                       dropped;
		edge_result_t               pending_q[$];
		int                         errors;

		function new();
			box = cet_pkg::BOX_RESET;
			cx = '0; cy = '0; cz = '0;
			center = '0;
			sx = 0; sy = 0; sz = 0;
			count = 0;
			dropped = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		// minimum-image component from c to p, box zero meaning 2^32
		function longint image(logic [cet_pkg::POS_W-1:0] c, logic [cet_pkg::POS_W-1:0] p);
			longint unsigned e, cm, pm, r;
			e = (box == 0) ? 64'h1_0000_0000 : {32'd0, box};
			cm = {32'd0, c} % e;
			pm = {32'd0, p} % e;
			r = (pm >= cm) ? pm - cm : pm + e - cm;
			if (2 * r > e)
				return longint'(r) - longint'(e);
			return longint'(r);
		endfunction

		function logic [127:0] square(longint s);
			logic [127:0] m;
			m = {64'd0, (s < 0) ? -s : s};
			return m * m;
		endfunction

		function void note_item(cet_pkg::mode_t mode, logic [cet_pkg::ID_W-1:0] id,
				logic [cet_pkg::POS_W-1:0] px, logic [cet_pkg::POS_W-1:0] py,
				logic [cet_pkg::POS_W-1:0] pz);
			edge_result_t res;
			logic [127:0] lhs, rhs;
			res.add_edge = 1'b0;
			case (mode)
				cet_pkg::MODE_START: begin
					cx = px; cy = py; cz = pz;
					center = id;
					sx = 0; sy = 0; sz = 0;
					count = 0;
					dropped = 1'b0;
				end
				cet_pkg::MODE_BOND: begin
					if (count < cet_pkg::MAX_NEIGHBORS) begin
						sx += image(cx, px);
						sy += image(cy, py);
						sz += image(cz, pz);
						count++;
					end else begin
						dropped = 1'b1;
					end
				end
				cet_pkg::MODE_CAND: begin
					// centroid moves closer when n^2|S+d|^2 < (n+1)^2|S|^2
					lhs = square(sx + image(cx, px)) + square(sy + image(cy, py))
						+ square(sz + image(cz, pz));
					rhs = square(sx) + square(sy) + square(sz);
					lhs = lhs * 128'(count * count);
					rhs = rhs * 128'((count + 1) * (count + 1));
					res.add_edge = (lhs < rhs);
				end
				default: begin
				end
			endcase
			res.center_id = center;
			res.partner_id = id;
			res.overflowed = dropped;
			pending_q.push_back(res);
		endfunction

		task check_result(logic add_edge, logic [cet_pkg::ID_W-1:0] center_id,
				logic [cet_pkg::ID_W-1:0] partner_id, logic overflowed);
			edge_result_t exp_res;
			if (pending_q.size() == 0) begin
				report("result with nothing pending");
				return;
			end
			exp_res = pending_q.pop_front();
			if (add_edge !== exp_res.add_edge)
				report($sformatf("add_edge %0b, want %0b (partner %h)",
					add_edge, exp_res.add_edge, exp_res.partner_id));
			if (center_id !== exp_res.center_id)
				report($sformatf("center_id %h, want %h", center_id, exp_res.center_id));
			if (partner_id !== exp_res.partner_id)
				report($sformatf("partner_id %h, want %h", partner_id, exp_res.partner_id));
			if (overflowed !== exp_res.overflowed)
				report($sformatf("overflowed %0b, want %0b", overflowed, exp_res.overflowed));
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         psel, penable, pwrite;
	logic [cet_pkg::PADDR_W-1:0]  paddr;
	logic [cet_pkg::PDATA_W-1:0]  pwdata;
	logic [cet_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	int                           send_idle, recv_idle;
	int                           hold_left;
	edge_scoreboard               sb;

	cet_in_if  items_if();
	cet_out_if res_if();

	centroid_edge_test_unit dut (
		.clk(clk), .arst_n(arst_n), .items(items_if), .results(res_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls plus an optional long hold-off
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.add_edge, res_if.center_id, res_if.partner_id,
				res_if.overflowed);
	end

	// random atom identifier
	function automatic logic [cet_pkg::ID_W-1:0] rand_id();
		logic [31:0] r;
		r = $urandom;
		return r[cet_pkg::ID_W-1:0];
	endfunction

	// config write, setup then access, called at a falling edge
	task automatic reg_write(logic [cet_pkg::PADDR_W-1:0] addr,
			logic [cet_pkg::PDATA_W-1:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.box = data;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// one input transfer; leaves valid high at the following falling edge
	task automatic send_atom(cet_pkg::mode_t mode, logic [cet_pkg::ID_W-1:0] id,
			logic [cet_pkg::POS_W-1:0] px, logic [cet_pkg::POS_W-1:0] py,
			logic [cet_pkg::POS_W-1:0] pz);
		while ($urandom_range(99) < send_idle) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.mode <= mode;
		items_if.atom_id <= id;
		items_if.pos_x <= px;
		items_if.pos_y <= py;
		items_if.pos_z <= pz;
		do @(posedge clk); while (!items_if.ready);
		sb.note_item(mode, id, px, py, pz);
		@(negedge clk);
	endtask

	// wait for all pending results, then let the pipeline settle
	task automatic drain();
		items_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		@(negedge clk);
	endtask

	// position near the center or anywhere
	function automatic logic [cet_pkg::POS_W-1:0] near(logic [cet_pkg::POS_W-1:0] c);
		logic [cet_pkg::POS_W-1:0] mask;
		if ($urandom_range(1) == 0)
			return $urandom;
		mask = 32'hFFFF_FFFF >> $urandom_range(31, 8);
		return c + ($urandom & mask) - (mask >> 1);
	endfunction

	// well-formed start, bonds and candidates, with some noise
	task automatic send_group(ref int sent);
		logic [cet_pkg::POS_W-1:0] x, y, z;
		int bonds, cands;
		x = $urandom; y = $urandom; z = $urandom;
		if ($urandom_range(9) == 0) begin
			send_atom(cet_pkg::mode_t'($urandom_range(3)), rand_id(), $urandom, $urandom,
				$urandom);
			sent++;
		end
		send_atom(cet_pkg::MODE_START, rand_id(), x, y, z);
		bonds = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
		cands = $urandom_range(4, 1);
		for (int i = 0; i < bonds; i++)
			send_atom(cet_pkg::MODE_BOND, rand_id(), near(x), near(y), near(z));
		for (int i = 0; i < cands; i++)
			send_atom(cet_pkg::MODE_CAND, rand_id(), near(x), near(y), near(z));
		sent += 1 + bonds + cands;
	endtask

	initial begin
		logic [cet_pkg::PDATA_W-1:0] boxes[6];
		int sent;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		items_if.valid = 1'b0; items_if.mode = cet_pkg::MODE_START; items_if.atom_id = '0;
		items_if.pos_x = '0; items_if.pos_y = '0; items_if.pos_z = '0;
		send_idle = 0; recv_idle = 0; hold_left = 0;
		boxes[0] = cet_pkg::BOX_RESET; boxes[1] = 32'd1; boxes[2] = 32'hFFFF_FFFF;
		boxes[3] = 32'd0; boxes[4] = $urandom; boxes[5] = 32'h0003_8000;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset state, idle mode, extremes, empty and small neighbor sets
		send_idle = 29; recv_idle = 51;
		send_atom(cet_pkg::MODE_CAND, 16'h1234, 32'h0000_8000, 32'd0, 32'd0);
		send_atom(cet_pkg::MODE_BOND, 16'h0001, 32'h0001_0000, 32'd0, 32'd0);
		send_atom(cet_pkg::MODE_CAND, 16'h0002, 32'hFFFF_FFFF, 32'h0008_0000, 32'd0);
		send_atom(cet_pkg::MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_atom(cet_pkg::MODE_START, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_atom(cet_pkg::MODE_CAND, 16'h0003, 32'd0, 32'd0, 32'd0);
		send_atom(cet_pkg::MODE_BOND, 16'h0004, 32'd0, 32'd0, 32'd0);
		send_atom(cet_pkg::MODE_BOND, 16'h0005, 32'hFFFF_FFFF, 32'h0008_0000, 32'h0007_FFFF);
		send_atom(cet_pkg::MODE_CAND, 16'h0006, 32'h0000_4000, 32'hFFFF_0000, 32'd0);
		send_atom(cet_pkg::MODE_CAND, 16'h0007, 32'h0010_0000, 32'h0020_0000, 32'hFFFF_FFFF);
		send_atom(cet_pkg::MODE_START, 16'h0000, 32'd0, 32'd0, 32'd0);
		send_atom(cet_pkg::MODE_BOND, 16'h0008, 32'h0001_0000, 32'h0001_0000, 32'd0);
		send_atom(cet_pkg::MODE_CAND, 16'h0009, 32'h0002_0000, 32'h0002_0000, 32'd0);
		send_atom(cet_pkg::MODE_CAND, 16'h000A, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0);
		send_atom(cet_pkg::MODE_NONE, 16'h000B, 32'd0, 32'd0, 32'd0);
		drain();

		// phases over box sizes and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			reg_write({cet_pkg::REG_BOX, 2'b00}, boxes[ph]);
			case (ph % 3)
				0: begin send_idle = 29; recv_idle = 51; end
				1: begin send_idle = 51; recv_idle = 29; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			sent = 0;
			// long receiver hold-off while items keep coming
			if (ph == 2)
				hold_left = 400;
			while (sent < 270) begin
				send_group(sent);
				// sender pause until everything is back
				if (ph == 1 && sent > 130 && sent < 150)
					drain();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/cet_pkg.sv
design/cet_if.sv
design/cet_front.sv
design/cet_queue.sv
design/cet_back.sv
design/centroid_edge_test_unit.sv
bench/tb_centroid_edge_test_unit.sv
